[rtl/core/chassis_inverse_kinematics_core_macros.svh]
// Assertion macros used by the chassis inverse kinematics top level.
`ifndef CHASSIS_INVERSE_KINEMATICS_CORE_MACROS_SVH
`define CHASSIS_INVERSE_KINEMATICS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CIK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CIK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cik_pkg.sv]
// Package: widths, types, constants and helper functions of the kinematics core.
`timescale 1ns / 1ps
package cik_pkg;

  localparam int WHEEL_COUNT       = 4;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int SQRT_STAGES       = 26;
  localparam int SQRT_W            = 52;
  localparam int CORDIC_W          = 36;
  localparam int COMP_W            = 34;
  localparam int SQ_IN_W           = 25;
  localparam int SPEED_W           = 18;
  localparam int ANGLE_W           = 16;

  // sqrt(2)/2 as unsigned Q0.16
  localparam logic [15:0] OMNI_K_Q16 = 16'd46341;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 18'sd131071;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = -18'sd131072;

  typedef enum logic [1:0] {
    MODE_SWERVE  = 2'd0,
    MODE_MECANUM = 2'd1,
    MODE_OMNI    = 2'd2,
    MODE_NONE    = 2'd3
  } drive_mode_t;

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // atan(2^-i) in binary angle units, 32768 = pi
  function automatic logic [ANGLE_W-1:0] atan_entry(input int i);
    logic [ANGLE_W-1:0] t;
    case (i)
      0:       t = 16'd8192;
      1:       t = 16'd4836;
      2:       t = 16'd2555;
      3:       t = 16'd1297;
      4:       t = 16'd651;
      5:       t = 16'd326;
      6:       t = 16'd163;
      7:       t = 16'd81;
      8:       t = 16'd41;
      9:       t = 16'd20;
      10:      t = 16'd10;
      11:      t = 16'd5;
      12:      t = 16'd3;
      13:      t = 16'd1;
      14:      t = 16'd1;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

  // clamp a rounded speed to the 18-bit range
  function automatic speed_t sat_speed(input logic signed [27:0] v);
    speed_t s;
    if (v > 28'sd131071) begin
      s = SPEED_MAX;
    end else if (v < -28'sd131072) begin
      s = SPEED_MIN;
    end else begin
      s = v[SPEED_W-1:0];
    end
    return s;
  endfunction

endpackage

[rtl/core/cik_if.sv]
// Valid/ready channel interfaces for velocity commands and wheel results.
`timescale 1ns / 1ps
interface cik_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] yaw_rate;
  modport source (output valid, output vel_x, output vel_y, output yaw_rate, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

interface cik_res_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] speed_0;
  logic signed [17:0] speed_1;
  logic signed [17:0] speed_2;
  logic signed [17:0] speed_3;
  logic signed [15:0] angle_0;
  logic signed [15:0] angle_1;
  logic signed [15:0] angle_2;
  logic signed [15:0] angle_3;
  modport source (output valid, output speed_0, output speed_1, output speed_2,
                  output speed_3, output angle_0, output angle_1, output angle_2,
                  output angle_3, input ready);
  modport sink   (input valid, input speed_0, input speed_1, input speed_2,
                  input speed_3, input angle_0, input angle_1, input angle_2,
                  input angle_3, output ready);
endinterface

[rtl/core/cik_front.sv]
// Front end: products, wheel vector components and linear-mode wheel speeds.
`timescale 1ns / 1ps
module cik_front import cik_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] yaw_rate,
  input  logic [15:0]        half_track_x,
  input  logic [15:0]        half_track_y,
  input  drive_mode_t        mode,
  output comp_t              cx  [WHEEL_COUNT],
  output comp_t              cy  [WHEEL_COUNT],
  output speed_t             lin [WHEEL_COUNT]
);

  // stage 1: sums and products
  logic signed [15:0] vx;
  logic signed [16:0] ap;
  logic signed [16:0] am;
  logic signed [32:0] wly;
  logic signed [32:0] wlx;
  logic signed [33:0] wl;
  logic signed [33:0] kp;
  logic signed [33:0] km;

  logic signed [16:0] ap_c;
  logic signed [16:0] am_c;
  logic [16:0]        lsum;

  assign ap_c = 17'(vel_x) + 17'(vel_y);
  assign am_c = 17'(vel_x) - 17'(vel_y);
  assign lsum = {1'b0, half_track_x} + {1'b0, half_track_y};

  always_ff @(posedge clk) begin
    if (en) begin
      vx  <= vel_x;
      ap  <= ap_c;
      am  <= am_c;
      wly <= yaw_rate * $signed({1'b0, half_track_y});
      wlx <= yaw_rate * $signed({1'b0, half_track_x});
      wl  <= yaw_rate * $signed({1'b0, lsum});
      kp  <= ap_c * $signed({1'b0, OMNI_K_Q16});
      km  <= am_c * $signed({1'b0, OMNI_K_Q16});
    end
  end

  // stage 2: components and rounded linear speeds
  logic signed [COMP_W-1:0] vx256;
  logic signed [COMP_W-1:0] vy256;
  logic signed [35:0]       mec   [WHEEL_COUNT];
  logic signed [43:0]       omn   [WHEEL_COUNT];
  logic signed [43:0]       r;
  comp_t                    cx_next [WHEEL_COUNT];
  comp_t                    cy_next [WHEEL_COUNT];
  speed_t                   lin_next [WHEEL_COUNT];

  always_comb begin
    vx256 = COMP_W'($signed({vx, 8'b0}));
    // vy = ap - vx
    vy256 = COMP_W'($signed({ap, 8'b0})) - vx256;
    cx_next[0] = vx256 - COMP_W'(wly);
    cx_next[1] = vx256 - COMP_W'(wly);
    cx_next[2] = vx256 + COMP_W'(wly);
    cx_next[3] = vx256 + COMP_W'(wly);
    cy_next[0] = vy256 + COMP_W'(wlx);
    cy_next[1] = vy256 - COMP_W'(wlx);
    cy_next[2] = vy256 - COMP_W'(wlx);
    cy_next[3] = vy256 + COMP_W'(wlx);

    mec[0] = 36'($signed({am, 8'b0})) + 36'(wl) + 36'sd128;
    mec[1] = -36'($signed({ap, 8'b0})) + 36'(wl) + 36'sd128;
    mec[2] = -36'($signed({am, 8'b0})) - 36'(wl) + 36'sd128;
    mec[3] = 36'($signed({ap, 8'b0})) - 36'(wl) + 36'sd128;

    r = 44'($signed({wl, 8'b0}));
    omn[0] = 44'(kp) + r + 44'sd32768;
    omn[1] = -44'(km) + r + 44'sd32768;
    omn[2] = -44'(kp) + r + 44'sd32768;
    omn[3] = 44'(km) + r + 44'sd32768;

    for (int k = 0; k < WHEEL_COUNT; k++) begin
      case (mode)
        MODE_MECANUM: lin_next[k] = sat_speed(mec[k][35:8]);
        MODE_OMNI:    lin_next[k] = sat_speed(omn[k][43:16]);
        default:      lin_next[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        cx[k]  <= cx_next[k];
        cy[k]  <= cy_next[k];
        lin[k] <= lin_next[k];
      end
    end
  end

endmodule

[rtl/core/cik_wheel.sv]
// One wheel lane: pipelined square root for magnitude and vectoring CORDIC for angle.
`timescale 1ns / 1ps
module cik_wheel import cik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  comp_t       cx,
  input  comp_t       cy,
  input  speed_t      lin,
  input  drive_mode_t mode,
  output speed_t      speed,
  output angle_t      angle
);

  localparam int DEPTH = (CORDIC_STAGES > SQRT_STAGES) ? CORDIC_STAGES : SQRT_STAGES;

  // lane stage 1: magnitudes, range and zero flags, CORDIC pre-rotation
  logic [COMP_W-1:0]          ax;
  logic [COMP_W-1:0]          ay;
  logic [SQ_IN_W-1:0]         sx;
  logic [SQ_IN_W-1:0]         sy;
  logic                       big1;
  logic                       zero1;
  logic signed [CORDIC_W-1:0] x1;
  logic signed [CORDIC_W-1:0] y1;
  logic [ANGLE_W-1:0]         z1;
  speed_t                     lin1;

  assign ax = cx[COMP_W-1] ? COMP_W'(-cx) : COMP_W'(cx);
  assign ay = cy[COMP_W-1] ? COMP_W'(-cy) : COMP_W'(cy);

  always_ff @(posedge clk) begin
    if (en) begin
      sx    <= ax[SQ_IN_W-1:0];
      sy    <= ay[SQ_IN_W-1:0];
      big1  <= (|ax[COMP_W-1:SQ_IN_W]) | (|ay[COMP_W-1:SQ_IN_W]);
      zero1 <= (cx == '0) && (cy == '0);
      x1    <= cx[COMP_W-1] ? -CORDIC_W'(cx) : CORDIC_W'(cx);
      y1    <= cx[COMP_W-1] ? -CORDIC_W'(cy) : CORDIC_W'(cy);
      z1    <= cx[COMP_W-1] ? 16'h8000 : 16'h0000;
      lin1  <= lin;
    end
  end

  // per-stage registers; index 0 is the squaring stage
  logic [SQRT_W-1:0]          n_s    [DEPTH+1];
  logic [SQRT_W-1:0]          r_s    [DEPTH+1];
  logic signed [CORDIC_W-1:0] x_s    [DEPTH+1];
  logic signed [CORDIC_W-1:0] y_s    [DEPTH+1];
  logic [ANGLE_W-1:0]         z_s    [DEPTH+1];
  logic                       big_s  [DEPTH+1];
  logic                       zero_s [DEPTH+1];
  speed_t                     lin_s  [DEPTH+1];

  // full-width squares
  logic [2*SQ_IN_W-1:0]       sxx;
  logic [2*SQ_IN_W-1:0]       syy;

  assign sxx = sx * sx;
  assign syy = sy * sy;

  // lane stage 2: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      n_s[0]    <= SQRT_W'(sxx) + SQRT_W'(syy);
      r_s[0]    <= '0;
      x_s[0]    <= x1;
      y_s[0]    <= y1;
      z_s[0]    <= z1;
      big_s[0]  <= big1;
      zero_s[0] <= zero1;
      lin_s[0]  <= lin1;
    end
  end

  // iteration stages: one root bit while j < SQRT_STAGES, one micro-rotation while j < CORDIC_STAGES
  for (genvar j = 0; j < DEPTH; j++) begin : g_stage
    localparam int SH = (j < SQRT_STAGES) ? 2 * (SQRT_STAGES - 1 - j) : 0;
    localparam logic [SQRT_W-1:0] RBIT = SQRT_W'(1) << SH;

    logic [SQRT_W-1:0]          trial;
    logic [SQRT_W-1:0]          n_next;
    logic [SQRT_W-1:0]          r_next;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic [ANGLE_W-1:0]         z_next;

    always_comb begin
      trial  = r_s[j] + RBIT;
      n_next = n_s[j];
      r_next = r_s[j];
      if (j < SQRT_STAGES) begin
        if (n_s[j] >= trial) begin
          n_next = n_s[j] - trial;
          r_next = (r_s[j] >> 1) + RBIT;
        end else begin
          r_next = r_s[j] >> 1;
        end
      end
      x_next = x_s[j];
      y_next = y_s[j];
      z_next = z_s[j];
      if (j < CORDIC_STAGES) begin
        if (!y_s[j][CORDIC_W-1]) begin
          x_next = x_s[j] + (y_s[j] >>> j);
          y_next = y_s[j] - (x_s[j] >>> j);
          z_next = z_s[j] + atan_entry(j);
        end else begin
          x_next = x_s[j] - (y_s[j] >>> j);
          y_next = y_s[j] + (x_s[j] >>> j);
          z_next = z_s[j] - atan_entry(j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_s[j+1]    <= n_next;
        r_s[j+1]    <= r_next;
        x_s[j+1]    <= x_next;
        y_s[j+1]    <= y_next;
        z_s[j+1]    <= z_next;
        big_s[j+1]  <= big_s[j];
        zero_s[j+1] <= zero_s[j];
        lin_s[j+1]  <= lin_s[j];
      end
    end
  end

  // round the Q.8 magnitude to an integer, clamp, select by drive mode
  logic [SQRT_STAGES:0] m8;
  speed_t               sw_speed;

  assign m8 = (SQRT_STAGES+1)'(((SQRT_STAGES+1)'(r_s[DEPTH][SQRT_STAGES-1:0]) + 128) >> 8);
  assign sw_speed = (big_s[DEPTH] || (m8 > (SQRT_STAGES+1)'(131071))) ? SPEED_MAX
                                                                      : m8[SPEED_W-1:0];

  always_comb begin
    case (mode)
      MODE_SWERVE: begin
        speed = sw_speed;
        angle = zero_s[DEPTH] ? '0 : z_s[DEPTH];
      end
      default: begin
        speed = lin_s[DEPTH];
        angle = '0;
      end
    endcase
  end

endmodule

[rtl/core/chassis_inverse_kinematics_core.sv]
// Top level: config registers, pipeline valid tracking, wheel lanes and output register.
// A command passes the front-end stages, the lane stages, the iteration stages and the output register.
// Throughput: one command per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// The depth is set by the 26-step square root and the CORDIC chain of each wheel lane.
// Reset (synchronous, active high) clears valid bits and config registers to zero.
`timescale 1ns / 1ps
`include "chassis_inverse_kinematics_core_macros.svh"
module chassis_inverse_kinematics_core import cik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cik_cmd_if.sink     cmd,
  cik_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = (CORDIC_STAGES > SQRT_STAGES) ? CORDIC_STAGES : SQRT_STAGES;
  localparam int VL    = 5 + DEPTH;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_LX   = 2'd1;
  localparam logic [1:0] REG_LY   = 2'd2;

  // configuration registers
  drive_mode_t drive_mode;
  logic [15:0] half_track_x;
  logic [15:0] half_track_y;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode   <= MODE_SWERVE;
      half_track_x <= '0;
      half_track_y <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MODE: drive_mode   <= drive_mode_t'(pwdata[1:0]);
        REG_LX:   half_track_x <= pwdata[15:0];
        REG_LY:   half_track_y <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE: prdata = {30'b0, drive_mode};
      REG_LX:   prdata = {16'b0, half_track_x};
      REG_LY:   prdata = {16'b0, half_track_y};
      default:  prdata = '0;
    endcase
  end

  // pipeline advance and valid bits
  logic advance;
  logic vld [VL];

  assign advance   = !vld[VL-1] || res.ready;
  assign cmd.ready = advance;
  assign res.valid = vld[VL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VL; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (advance) begin
      vld[0] <= cmd.valid;
      for (int i = 1; i < VL; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // front end
  comp_t  cx  [WHEEL_COUNT];
  comp_t  cy  [WHEEL_COUNT];
  speed_t lin [WHEEL_COUNT];

  cik_front u_front (
    .clk          (clk),
    .en           (advance),
    .vel_x        (cmd.vel_x),
    .vel_y        (cmd.vel_y),
    .yaw_rate     (cmd.yaw_rate),
    .half_track_x (half_track_x),
    .half_track_y (half_track_y),
    .mode         (drive_mode),
    .cx           (cx),
    .cy           (cy),
    .lin          (lin)
  );

  // wheel lanes
  speed_t w_speed [WHEEL_COUNT];
  angle_t w_angle [WHEEL_COUNT];

  for (genvar k = 0; k < WHEEL_COUNT; k++) begin : g_wheel
    cik_wheel #(
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_wheel (
      .clk   (clk),
      .en    (advance),
      .cx    (cx[k]),
      .cy    (cy[k]),
      .lin   (lin[k]),
      .mode  (drive_mode),
      .speed (w_speed[k]),
      .angle (w_angle[k])
    );
  end

  // output register
  speed_t out_speed [WHEEL_COUNT];
  angle_t out_angle [WHEEL_COUNT];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        out_speed[k] <= w_speed[k];
        out_angle[k] <= w_angle[k];
      end
    end
  end

  assign res.speed_0 = out_speed[0];
  assign res.speed_1 = out_speed[1];
  assign res.speed_2 = out_speed[2];
  assign res.speed_3 = out_speed[3];
  assign res.angle_0 = out_angle[0];
  assign res.angle_1 = out_angle[1];
  assign res.angle_2 = out_angle[2];
  assign res.angle_3 = out_angle[3];

  // checks
  `CIK_ASSERT_NEXT(a_accept_enters, cmd.valid && cmd.ready, vld[0], "accepted command lost at entry")
  `CIK_ASSERT_NEXT(a_stall_holds, !advance, vld[VL-1] && $stable(res.speed_0) && $stable(res.angle_0), "stalled result changed")
  `CIK_ASSERT_IMPL(a_linear_angles, res.valid && (drive_mode != MODE_SWERVE), (res.angle_0 == 0) && (res.angle_1 == 0) && (res.angle_2 == 0) && (res.angle_3 == 0), "nonzero angle in linear mode")
  `CIK_ASSERT_IMPL(a_none_zero, res.valid && (drive_mode == MODE_NONE), (res.speed_0 == 0) && (res.speed_3 == 0), "nonzero speed in unknown mode")

endmodule

[verif/tb_chassis_inverse_kinematics_core.sv]
// Testbench for the chassis inverse kinematics core: directed table, random commands, scoreboard.
`timescale 1ns / 1ps
module tb_chassis_inverse_kinematics_core;
  import cik_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 200;
  localparam logic [3:0] ADDR_MODE = 4'd0;
  localparam logic [3:0] ADDR_LX = 4'd4;
  localparam logic [3:0] ADDR_LY = 4'd8;

  typedef struct {
    speed_t speed[WHEEL_COUNT];
    angle_t angle[WHEEL_COUNT];
  } wheels_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [15:0] lx;
    logic [15:0] ly;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] w;
    logic zero_exp;
  } cmd_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cik_cmd_if cmd ();
  cik_res_if res ();

  chassis_inverse_kinematics_core DUT (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow configuration
  drive_mode_t cur_mode;
  logic [15:0] cur_lx;
  logic [15:0] cur_ly;

  wheels_t expected_wheels[$];
  int errors;
  int received;
  bit calm;
  bit stim_done;

  cmd_row_t cmd_table[20] = '{
    '{MODE_SWERVE, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
    '{MODE_SWERVE, 16'd0, 16'd0, 16'sd256, 16'sd0, 16'sd0, 1'b0},
    '{MODE_SWERVE, 16'd0, 16'd0, 16'sd0, 16'sd256, 16'sd0, 1'b0},
    '{MODE_SWERVE, 16'd0, 16'd0, -16'sd256, 16'sd0, 16'sd0, 1'b0},
    '{MODE_SWERVE, 16'd0, 16'd0, 16'sd0, -16'sd256, 16'sd0, 1'b0},
    '{MODE_SWERVE, 16'd0, 16'd0, 16'sd32767, 16'sd32767, 16'sd0, 1'b0},
    '{MODE_SWERVE, 16'd0, 16'd0, -16'sd32768, -16'sd32768, 16'sd0, 1'b0},
    '{MODE_SWERVE, 16'd65535, 16'd65535, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0},
    '{MODE_SWERVE, 16'd256, 16'd256, 16'sd0, 16'sd0, 16'sd256, 1'b0},
    '{MODE_MECANUM, 16'd256, 16'd128, 16'sd256, 16'sd0, 16'sd0, 1'b0},
    '{MODE_MECANUM, 16'd256, 16'd128, 16'sd0, 16'sd256, 16'sd0, 1'b0},
    '{MODE_MECANUM, 16'd256, 16'd128, 16'sd0, 16'sd0, -16'sd256, 1'b0},
    '{MODE_MECANUM, 16'd65535, 16'd65535, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0},
    '{MODE_MECANUM, 16'd65535, 16'd65535, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0},
    '{MODE_OMNI, 16'd256, 16'd256, 16'sd256, 16'sd256, 16'sd0, 1'b0},
    '{MODE_OMNI, 16'd256, 16'd256, -16'sd256, 16'sd0, 16'sd256, 1'b0},
    '{MODE_OMNI, 16'd65535, 16'd65535, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0},
    '{MODE_OMNI, 16'd0, 16'd0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0},
    '{MODE_NONE, 16'd256, 16'd256, 16'sd1000, -16'sd1000, 16'sd500, 1'b1},
    '{MODE_NONE, 16'd65535, 16'd65535, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1}
  };

  // ---------------- predictor ----------------
  function automatic speed_t clamp_speed(input longint v);
    speed_t s;
    if (v > 131071) begin
      s = SPEED_MAX;
    end else if (v < -131072) begin
      s = SPEED_MIN;
    end else begin
      s = v[SPEED_W-1:0];
    end
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic angle_t steer_angle(input longint x_in, input longint y_in);
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint z;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return '0;
    // left half-plane: flip into the right half and start at pi
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_entry(i));
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_entry(i));
      end
    end
    return z[15:0];
  endfunction

  function automatic wheels_t predict_wheels(input logic signed [15:0] vx_i,
                                             input logic signed [15:0] vy_i,
                                             input logic signed [15:0] w_i);
    wheels_t r;
    longint vx;
    longint vy;
    longint w;
    longint lx;
    longint ly;
    longint wl;
    longint cx[WHEEL_COUNT];
    longint cy[WHEEL_COUNT];
    longint s[WHEEL_COUNT];
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned mag;
    vx = vx_i;
    vy = vy_i;
    w = w_i;
    lx = {48'd0, cur_lx};
    ly = {48'd0, cur_ly};
    wl = w * (lx + ly);
    for (int k = 0; k < WHEEL_COUNT; k++) begin
      r.speed[k] = '0;
      r.angle[k] = '0;
    end
    case (cur_mode)
      MODE_SWERVE: begin
        cx[0] = vx * 256 - w * ly; cx[1] = cx[0];
        cx[2] = vx * 256 + w * ly; cx[3] = cx[2];
        cy[0] = vy * 256 + w * lx; cy[3] = cy[0];
        cy[1] = vy * 256 - w * lx; cy[2] = cy[1];
        for (int k = 0; k < WHEEL_COUNT; k++) begin
          ax = (cx[k] < 0) ? -cx[k] : cx[k];
          ay = (cy[k] < 0) ? -cy[k] : cy[k];
          mag = (int_sqrt(ax * ax + ay * ay) + 128) >> 8;
          if (mag > 131071) mag = 131071;
          r.speed[k] = clamp_speed(longint'(mag));
          r.angle[k] = steer_angle(cx[k], cy[k]);
        end
      end
      MODE_MECANUM: begin
        s[0] = (vx - vy) * 256 + wl;
        s[1] = (-vx - vy) * 256 + wl;
        s[2] = (-vx + vy) * 256 - wl;
        s[3] = (vx + vy) * 256 - wl;
        for (int k = 0; k < WHEEL_COUNT; k++) r.speed[k] = clamp_speed((s[k] + 128) >>> 8);
      end
      MODE_OMNI: begin
        s[0] = 46341 * (vx + vy) + wl * 256;
        s[1] = 46341 * (-vx + vy) + wl * 256;
        s[2] = 46341 * (-vx - vy) + wl * 256;
        s[3] = 46341 * (vx - vy) + wl * 256;
        for (int k = 0; k < WHEEL_COUNT; k++) r.speed[k] = clamp_speed((s[k] + 32768) >>> 16);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- clock, reset, limit ----------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // drain the pipeline, then load all three registers
  task automatic set_drive(input logic [1:0] mode, input logic [15:0] lx,
                           input logic [15:0] ly);
    cmd.valid = 1'b0;
    wait (expected_wheels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_write(ADDR_MODE, {30'd0, mode});
    reg_write(ADDR_LX, {16'd0, lx});
    reg_write(ADDR_LY, {16'd0, ly});
    cur_mode = drive_mode_t'(mode);
    cur_lx = lx;
    cur_ly = ly;
  endtask

  // offer one command and wait for its transaction
  task automatic send_cmd(input logic signed [15:0] vx, input logic signed [15:0] vy,
                          input logic signed [15:0] w, input bit zero_exp);
    wheels_t e;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.vel_x = vx;
    cmd.vel_y = vy;
    cmd.yaw_rate = w;
    do @(posedge clk); while (!cmd.ready);
    e = predict_wheels(vx, vy, w);
    if (zero_exp) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        e.speed[k] = '0;
        e.angle[k] = '0;
      end
    end
    expected_wheels.push_back(e);
    @(negedge clk);
  endtask

  // ---------------- main sequence ----------------
  initial begin
    logic [1:0] mode;
    logic [15:0] lx;
    logic [15:0] ly;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cmd.valid = 1'b0; cmd.vel_x = '0; cmd.vel_y = '0; cmd.yaw_rate = '0;
    cur_mode = MODE_SWERVE; cur_lx = '0; cur_ly = '0;
    errors = 0; calm = 1'b0; stim_done = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed table; registers start at their reset value
    foreach (cmd_table[i]) begin
      if (cmd_table[i].mode != cur_mode || cmd_table[i].lx != cur_lx ||
          cmd_table[i].ly != cur_ly) begin
        set_drive(cmd_table[i].mode, cmd_table[i].lx, cmd_table[i].ly);
      end
      send_cmd(cmd_table[i].vx, cmd_table[i].vy, cmd_table[i].w, cmd_table[i].zero_exp);
    end

    // random phases across every mode and the spacing extremes
    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = 2'(p % 4);
      if (p == 1 || p == 6) begin
        lx = 16'hFFFF; ly = 16'hFFFF;
      end else if (p == 2 || p == 5) begin
        lx = 16'h0000; ly = 16'h0000;
      end else begin
        lx = 16'($urandom); ly = 16'($urandom);
      end
      set_drive(mode, lx, ly);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm = (n % 100) >= 80;
        send_cmd(rand_field(), rand_field(), rand_field(), 1'b0);
      end
      calm = 1'b0;
    end
    cmd.valid = 1'b0;
    stim_done = 1'b1;

    wait (expected_wheels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------- result side backpressure ----------------
  initial begin
    int stall;
    int hold;
    bit held;
    stall = 0; hold = 0; held = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      // one long hold-off so the pipeline fills and stalls the command side
      if (!held && received >= 600) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        res.ready = 1'b0;
      end else if (stall > 0) begin
        stall--;
        res.ready = 1'b0;
      end else begin
        res.ready = 1'b1;
        if ($urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  // ---------------- scoreboard ----------------
  initial received = 0;

  always @(posedge clk) begin
    wheels_t e;
    wheels_t got;
    if (!rst && res.valid && res.ready) begin
      received <= received + 1;
      got.speed[0] = res.speed_0; got.speed[1] = res.speed_1;
      got.speed[2] = res.speed_2; got.speed[3] = res.speed_3;
      got.angle[0] = res.angle_0; got.angle[1] = res.angle_1;
      got.angle[2] = res.angle_2; got.angle[3] = res.angle_3;
      if (expected_wheels.size() == 0) begin
        $display("%0t: unexpected result transaction, speed_0 %0d", $realtime, got.speed[0]);
        errors++;
      end else begin
        e = expected_wheels.pop_front();
        for (int k = 0; k < WHEEL_COUNT; k++) begin
          if (got.speed[k] !== e.speed[k]) begin
            $display("%0t: speed_%0d expected %0d actual %0d", $realtime, k,
                     e.speed[k], got.speed[k]);
            errors++;
          end
          if (got.angle[k] !== e.angle[k]) begin
            $display("%0t: angle_%0d expected %0d actual %0d", $realtime, k,
                     e.angle[k], got.angle[k]);
            errors++;
          end
        end
      end
    end
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cik_pkg.sv
rtl/core/cik_if.sv
rtl/core/cik_front.sv
rtl/core/cik_wheel.sv
rtl/core/chassis_inverse_kinematics_core.sv
verif/tb_chassis_inverse_kinematics_core.sv
